// ===== design/dtcq_pkg.sv =====
// Types and codes shared by the deadline timer queue modules.
package dtcq_pkg;

  localparam logic [1:0] CMD_ARM_ABS = 2'd0;
  localparam logic [1:0] CMD_ARM_REL = 2'd1;
  localparam logic [1:0] CMD_CANCEL  = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [15:0] MIN_INTERVAL_RESET = 16'd50;
  localparam logic [15:0] MAX_INTERVAL_RESET = 16'd50000;

  localparam logic [3:0] REG_MIN_INTERVAL = 4'd0;
  localparam logic [3:0] REG_MAX_INTERVAL = 4'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [63:0] time_value;
    logic [63:0] repeat_period;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_slot;
    logic [63:0] fired_deadline;
    logic [63:0] next_compare;
    logic        slot_idle;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_APPLY, ST_SCAN, ST_FIRE, ST_REARM, ST_NEXT, ST_EMIT
  } exec_state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[64] ? '1 : r[63:0];
  endfunction

endpackage

// ===== design/deadline_timer_callout_queue_unit.sv =====
// Top level of the deadline-ordered timer queue.
// Usage:
//  - in channel (in_valid/in_ready/in_item): arm, cancel or tick beats.
//  - out channel (out_valid/out_ready/out_item): result beats; fired beats
//    come first in firing order and only the final beat of an item has last.
//  - cfg_we/cfg_idx/cfg_data: min_interval (0) and max_interval (1),
//    written only while no item is in flight; the block does not enforce it.
// The back end works one item at a time and scans the slot table one slot a
// cycle. A tick rescans the table after every fire. The back end takes no new
// item until it has loaded the last result beat of the current one.
// A two-beat input queue accepts beats while the back end is busy.
// Reset clears all slot active bits, the arm counter and the queue, and
// loads the interval registers with 50 and 50000.
// When the receiver stalls the back end holds in place with its result
// registered; no beat is lost.
module deadline_timer_callout_queue_unit import dtcq_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int MAX_FIRES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [3:0] cfg_idx,
  input  logic [15:0] cfg_data
);
  logic     q_valid, q_ready;
  in_item_t q_item;

  dtcq_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  dtcq_back #(.SLOTS(SLOTS), .MAX_FIRES(MAX_FIRES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .cfg_we, .cfg_idx, .cfg_data,
    .out_valid, .out_ready, .out_item
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");
  a_fire_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_FIRED |-> !out_item.last)
    else $error("fired beat marked last");
`endif
endmodule

// ===== design/dtcq_front.sv =====
// Front end: input skid queue of two beats feeding the executor.
module dtcq_front import dtcq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_ready,
  output in_item_t q_item
);
  in_item_t   mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_item;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

// ===== design/dtcq_back.sv =====
// Back end: slot table, sequential earliest-deadline scan and result output.
module dtcq_back import dtcq_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int MAX_FIRES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  in_item_t  q_item,
  input  logic      cfg_we,
  input  logic [3:0] cfg_idx,
  input  logic [15:0] cfg_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW  = $clog2(MAX_FIRES + 1);
  localparam int FIW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;

  logic [63:0] dl [SLOTS];
  logic [63:0] per [SLOTS];
  logic [31:0] stamp [SLOTS];
  logic [SLOTS-1:0] active;
  logic [31:0] arm_seq;
  logic [15:0] min_iv, max_iv;

  // fires of the current tick, replayed once next_compare is known
  logic [3:0]  fb_slot [MAX_FIRES];
  logic [63:0] fb_dl [MAX_FIRES];

  exec_state_t st, st_next;
  in_item_t    cur;
  logic [SW-1:0] idx;
  logic        best_ok;
  logic [SW-1:0] best;
  logic [FW-1:0] nfires, ecnt;
  logic [63:0] nc;
  out_item_t   obuf;
  logic        obuf_v;

  logic [SW-1:0] cur_s;
  logic [31:0] stamp_diff;
  logic        slot_ok, cand_better, idle_now, fire_go, out_free, emit_load;
  logic [63:0] lo, hi;

  assign cur_s   = cur.slot[SW-1:0];
  assign slot_ok = ({4'd0, cur.slot} < 8'(SLOTS));
  // equal deadlines: the older stamp wins, age by sign of the difference
  assign stamp_diff  = stamp[idx] - stamp[best];
  assign cand_better = active[idx] && (!best_ok || dl[idx] < dl[best] ||
    (dl[idx] == dl[best] && stamp_diff[31]));
  assign lo = sat_add(cur.now, {48'd0, min_iv});
  assign hi = sat_add(cur.now, {48'd0, max_iv});
  assign idle_now  = !(slot_ok && active[cur_s]);
  assign fire_go   = (nfires != FW'(MAX_FIRES)) && best_ok && (dl[best] <= cur.now);
  assign out_free  = !obuf_v || out_ready;
  assign emit_load = (st == ST_EMIT) && out_free;

  assign q_ready   = (st == ST_IDLE);
  assign out_valid = obuf_v;
  assign out_item  = obuf;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE:  if (q_valid) st_next = ST_APPLY;
      ST_APPLY: st_next = ST_SCAN;
      ST_SCAN:  if (idx == SW'(SLOTS - 1))
                  st_next = (cur.cmd == CMD_TICK) ? ST_FIRE : ST_NEXT;
      ST_FIRE:  st_next = fire_go ? ST_REARM : ST_NEXT;
      ST_REARM: st_next = ST_SCAN;
      ST_NEXT:  st_next = ST_EMIT;
      ST_EMIT:  if (out_free && ecnt == nfires) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // table updates, scan and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      active <= '0;
      arm_seq <= '0;
      min_iv <= MIN_INTERVAL_RESET;
      max_iv <= MAX_INTERVAL_RESET;
      obuf_v <= 1'b0;
      idx <= '0;
      best <= '0;
      best_ok <= 1'b0;
      nfires <= '0;
      ecnt <= '0;
    end else begin
      st <= st_next;
      if (cfg_we && cfg_idx == REG_MIN_INTERVAL) min_iv <= cfg_data;
      if (cfg_we && cfg_idx == REG_MAX_INTERVAL) max_iv <= cfg_data;
      if (emit_load) obuf_v <= 1'b1;
      else if (out_ready) obuf_v <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            nfires <= '0;
          end
        end
        ST_APPLY: begin
          idx <= '0;
          best_ok <= 1'b0;
          if (slot_ok && (cur.cmd == CMD_ARM_ABS || cur.cmd == CMD_ARM_REL)) begin
            dl[cur_s] <= (cur.cmd == CMD_ARM_ABS) ? cur.time_value :
                         sat_add(cur.now, cur.time_value);
            per[cur_s] <= cur.repeat_period;
            stamp[cur_s] <= arm_seq;
            active[cur_s] <= 1'b1;
            arm_seq <= arm_seq + 32'd1;
          end else if (slot_ok && cur.cmd == CMD_CANCEL) begin
            active[cur_s] <= 1'b0;
            per[cur_s] <= '0;
          end
        end
        ST_SCAN: begin
          if (cand_better) begin
            best <= idx;
            best_ok <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        ST_FIRE: begin
          if (fire_go) begin
            active[best] <= 1'b0;
            fb_slot[nfires[FIW-1:0]] <= 4'(best);
            fb_dl[nfires[FIW-1:0]] <= dl[best];
            nfires <= nfires + 1'b1;
          end
        end
        ST_REARM: begin
          idx <= '0;
          best_ok <= 1'b0;
          if (per[best] != 64'd0) begin
            dl[best] <= sat_add(dl[best], per[best]);
            stamp[best] <= arm_seq;
            active[best] <= 1'b1;
            arm_seq <= arm_seq + 32'd1;
          end
        end
        ST_NEXT: begin
          // last scan covered the final table
          nc <= (!best_ok) ? hi : (dl[best] <= lo) ? lo : (dl[best] < hi) ? dl[best] : hi;
          ecnt <= '0;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (ecnt != nfires) begin
              obuf.kind <= KIND_FIRED;
              obuf.fired_slot <= fb_slot[ecnt[FIW-1:0]];
              obuf.fired_deadline <= fb_dl[ecnt[FIW-1:0]];
              obuf.last <= 1'b0;
              ecnt <= ecnt + 1'b1;
            end else begin
              obuf.kind <= (cur.cmd == CMD_TICK) ? KIND_DONE : KIND_ACK;
              obuf.fired_slot <= '0;
              obuf.fired_deadline <= '0;
              obuf.last <= 1'b1;
            end
            obuf.next_compare <= nc;
            obuf.slot_idle <= idle_now;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the deadline-ordered timer queue unit.
`timescale 1ns / 1ps

module testbench import dtcq_pkg::*;;

  localparam int NSLOT = 16;
  localparam int FIRE_CAP = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  deadline_timer_callout_queue_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer table mirror
  logic [63:0] tbl_deadline [NSLOT];
  logic [63:0] tbl_period [NSLOT];
  logic        tbl_active [NSLOT];
  logic [31:0] tbl_stamp [NSLOT];
  logic [31:0] arm_count;
  logic [15:0] min_ivl, max_ivl;

  in_item_t  pending_cmds [$];
  out_item_t expected_beats [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[64] ? {64{1'b1}} : r[63:0];
  endfunction

  function automatic int earliest_slot();
    int best;
    logic [31:0] diff;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_active[i]) continue;
      diff = tbl_stamp[i] - (best < 0 ? 32'd0 : tbl_stamp[best]);
      if (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
          (tbl_deadline[i] == tbl_deadline[best] && diff[31]))
        best = i;
    end
    return best;
  endfunction

  function automatic void arm_slot(int s, logic [63:0] dl, logic [63:0] per);
    tbl_deadline[s] = dl;
    tbl_period[s] = per;
    tbl_active[s] = 1'b1;
    tbl_stamp[s] = arm_count;
    arm_count = arm_count + 1;
  endfunction

  // predict all result beats for one command
  function automatic void predict_beats(in_item_t it);
    logic [3:0]  fslot [FIRE_CAP];
    logic [63:0] fdl [FIRE_CAP];
    int nf, e;
    logic [63:0] lo, hi, nc, d;
    logic idle;
    out_item_t o;
    nf = 0;
    case (it.cmd)
      CMD_ARM_ABS: arm_slot(int'(it.slot), it.time_value, it.repeat_period);
      CMD_ARM_REL: arm_slot(int'(it.slot), add_sat(it.now, it.time_value),
                            it.repeat_period);
      CMD_CANCEL: begin
        tbl_active[it.slot] = 1'b0;
        tbl_period[it.slot] = '0;
      end
      default: begin
        while (nf < FIRE_CAP) begin
          e = earliest_slot();
          if (e < 0 || tbl_deadline[e] > it.now) break;
          d = tbl_deadline[e];
          tbl_active[e] = 1'b0;
          fslot[nf] = e[3:0];
          fdl[nf] = d;
          nf++;
          if (tbl_period[e] != 0) arm_slot(e, add_sat(d, tbl_period[e]), tbl_period[e]);
        end
      end
    endcase
    // clamped next compare
    lo = add_sat(it.now, {48'd0, min_ivl});
    hi = add_sat(it.now, {48'd0, max_ivl});
    nc = hi;
    e = earliest_slot();
    if (e >= 0) begin
      if (tbl_deadline[e] <= lo) nc = lo;
      else if (tbl_deadline[e] < hi) nc = tbl_deadline[e];
    end
    idle = !tbl_active[it.slot];
    for (int k = 0; k < nf; k++) begin
      o = '{kind: KIND_FIRED, fired_slot: fslot[k], fired_deadline: fdl[k],
            next_compare: nc, slot_idle: idle, last: 1'b0};
      expected_beats.push_back(o);
    end
    o = '{kind: (it.cmd == CMD_TICK) ? KIND_DONE : KIND_ACK, fired_slot: 4'd0,
          fired_deadline: 64'd0, next_compare: nc, slot_idle: idle, last: 1'b1};
    expected_beats.push_back(o);
  endfunction

  // driver: presents queued commands, idles at random
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_beats(in_item);
      if (!(in_valid && !in_ready)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and compare against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %p", out_item);
        end else begin
          want = expected_beats.pop_front();
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat mismatch: expected %p actual %p", want, out_item);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] c, logic [3:0] s, logic [63:0] tv,
                                        logic [63:0] per, logic [63:0] t);
    in_item_t it;
    it.cmd = c; it.slot = s; it.time_value = tv; it.repeat_period = per; it.now = t;
    return it;
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    // no-result window after the last ack is nil, but let the back end settle
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_INTERVAL) min_ivl = val; else max_ivl = val;
  endtask

  // well-formed random traffic around a moving clock
  task automatic random_phase(int count, logic [63:0] base);
    logic [63:0] t;
    int r;
    t = base;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 35)
        pending_cmds.push_back(make_cmd(CMD_ARM_REL, 4'($urandom_range(15)),
          64'($urandom_range(400)),
          ($urandom_range(2) == 0) ? 64'd0 : 64'($urandom_range(300)), t));
      else if (r < 45)
        pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'($urandom_range(15)),
          t + 64'($urandom_range(200)), $urandom_range(1) ? 64'd0 : 64'd50, t));
      else if (r < 52)
        pending_cmds.push_back(make_cmd(CMD_CANCEL, 4'($urandom_range(15)), rand64(),
          rand64(), t));
      else if (r < 56)
        pending_cmds.push_back(make_cmd(2'($urandom_range(2)), 4'($urandom_range(15)),
          rand64(), rand64(), rand64()));
      else begin
        t = t + 64'($urandom_range(250));
        pending_cmds.push_back(make_cmd(CMD_TICK, 4'($urandom_range(15)), rand64(),
          rand64(), t));
      end
    end
    // clear the table so later phases start from known timing
    for (int s = 0; s < NSLOT; s++)
      pending_cmds.push_back(make_cmd(CMD_CANCEL, 4'(s), 64'd0, 64'd0, t));
  endtask

  initial begin
    logic [63:0] top;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_active[i] = 1'b0; tbl_period[i] = '0; tbl_deadline[i] = '0; tbl_stamp[i] = '0;
    end
    arm_count = '0;
    min_ivl = MIN_INTERVAL_RESET;
    max_ivl = MAX_INTERVAL_RESET;
    top = {64{1'b1}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 28; recv_idle_pct = 53;

    // directed: extremes, ties, saturation, same-tick re-arm, odd clamps
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd0, 64'd0, 64'd0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd15, 64'd100, 64'd0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd3, 64'd100, 64'd0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd0, 64'd100, 64'd0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_ARM_REL, 4'd7, top, top, top - 5));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd5, 64'd10, 64'd30, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd5, 64'd0, 64'd0, 64'd200));
    pending_cmds.push_back(make_cmd(CMD_CANCEL, 4'd5, top, top, 64'd200));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd1, 64'd10, 64'd1, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd1, 64'd0, 64'd0, 64'd1000));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd1, 64'd0, 64'd0, 64'd1000));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd7, top, top, top));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd2, top, 64'd0, top - 3));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd2, 64'd0, 64'd0, top - 1));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd9, 64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd9, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    for (int s = 0; s < NSLOT; s++)
      pending_cmds.push_back(make_cmd(CMD_CANCEL, 4'(s), 64'd0, 64'd0, 64'd0));
    drain();

    // odd register settings
    write_reg(REG_MIN_INTERVAL, 16'd65535);
    write_reg(REG_MAX_INTERVAL, 16'd1);
    pending_cmds.push_back(make_cmd(CMD_ARM_ABS, 4'd4, 64'd30, 64'd0, 64'd0));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd4, 64'd0, 64'd0, 64'd10));
    pending_cmds.push_back(make_cmd(CMD_TICK, 4'd4, 64'd0, 64'd0, top));
    drain();
    write_reg(REG_MIN_INTERVAL, 16'd1);
    write_reg(REG_MAX_INTERVAL, 16'd65535);
    random_phase(100, 64'd1000);
    drain();

    send_idle_pct = 53; recv_idle_pct = 28;
    write_reg(REG_MIN_INTERVAL, 16'd20);
    write_reg(REG_MAX_INTERVAL, 16'd300);
    random_phase(100, top - 64'd20000);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_MIN_INTERVAL, MIN_INTERVAL_RESET);
    write_reg(REG_MAX_INTERVAL, MAX_INTERVAL_RESET);
    random_phase(100, 64'd5_000_000);
    drain();

    if (mismatches == 0 && expected_beats.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
